>>> src/mil_pkg.sv
package mil_pkg;

  localparam int DATA_W = 32;
  localparam int DIM_W  = 4;
  localparam int STAT_W = 2;

  localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
  localparam logic [STAT_W-1:0] ST_SINGULAR = 2'd1;
  localparam logic [STAT_W-1:0] ST_OVERFLOW = 2'd2;

  localparam logic [DATA_W-1:0] FX_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic [DATA_W-1:0] FX_MIN = {1'b1, {(DATA_W-1){1'b0}}};

  // Result of one arithmetic operation, with its saturation flag.
  typedef struct packed {
    logic              done;
    logic              sat;
    logic [DATA_W-1:0] value;
  } fx_res_t;

  // Saturating add or subtract; the top bit of the return value flags saturation.
  function automatic logic [DATA_W:0] fx_addsub(input logic [DATA_W-1:0] a,
                                                input logic [DATA_W-1:0] b,
                                                input logic sub);
    logic [DATA_W:0] s;
    logic [DATA_W:0] r;
    s = sub ? ({a[DATA_W-1], a} - {b[DATA_W-1], b})
            : ({a[DATA_W-1], a} + {b[DATA_W-1], b});
    if (s[DATA_W] != s[DATA_W-1]) begin
      r = {1'b1, (s[DATA_W] ? FX_MIN : FX_MAX)};
    end else begin
      r = {1'b0, s[DATA_W-1:0]};
    end
    return r;
  endfunction

endpackage

>>> src/matrix_inverse_lu_unit.sv
// Fixed-point matrix inverter (Crout LU, no pivoting), signed Q16.16 by default.
// Input channel: a word is taken at a clock edge where start is high and busy is
// low; element carries one matrix entry in row-major order and last_in marks the
// final one. Entries that never arrive after an early last_in count as zero, and
// the matrix also completes by itself after n*n words.
// Configuration: cfg_we writes cfg_wdata into the order register dim (reset 3);
// dim 0 acts as 1 and values above MAX_DIM act as MAX_DIM. A write also drops a
// partial load, and busy is high in the cycle of the write so no word is taken
// alongside it. Write it only while the block is idle.
// Output channel: n*n result words in row-major order, each present for exactly
// one cycle while result_valid is high; last_out marks the final word. status is
// the same on every word: 0 ok, 1 singular (all values zero), 2 saturation.
// The receiver cannot stall the block; it must take every word as it appears.
// Loading accepts one word per cycle while busy is low. After the last word busy
// stays high while one shared multiplier and one shared radix-2 divider do all
// the work (roughly n^3 multiply-accumulates and n^2 divisions), each entry is
// stored, and then the n*n result words are sent out.
// Reset returns the block to idle with an empty load and dim set to 3.
module matrix_inverse_lu_unit import mil_pkg::*; #(
  parameter int MAX_DIM   = 8,
  parameter int FRAC_BITS = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  logic [DATA_W-1:0] element,
  input  logic              last_in,
  input  logic              cfg_we,
  input  logic [DIM_W-1:0]  cfg_wdata,
  output logic              result_valid,
  output logic [DATA_W-1:0] inv_value,
  output logic              last_out,
  output logic [STAT_W-1:0] status
);

  localparam int IW = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int CW = $clog2(MAX_DIM + 1);
  localparam int AW = 2 * IW;
  localparam int MD = 1 << AW;
  localparam logic [DATA_W-1:0] FX_ONE = DATA_W'(1) << FRAC_BITS;

  // Sequencer states.
  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_SRC  = 4'd1;
  localparam logic [3:0] S_INIT = 4'd2;
  localparam logic [3:0] S_RD   = 4'd3;
  localparam logic [3:0] S_OP   = 4'd4;
  localparam logic [3:0] S_WAIT = 4'd5;
  localparam logic [3:0] S_POST = 4'd6;
  localparam logic [3:0] S_DIV  = 4'd7;
  localparam logic [3:0] S_WR   = 4'd8;
  localparam logic [3:0] S_EMIT = 4'd9;

  // Phases of the computation. Every phase builds entry (ii, jj) of some
  // matrix as a dot product over m of A(ii, m) and B(m, jj).
  localparam logic [2:0] PH_L   = 3'd0;  // lower factor column jj
  localparam logic [2:0] PH_U   = 3'd1;  // upper factor row ii
  localparam logic [2:0] PH_LI  = 3'd2;  // inverse of the lower factor
  localparam logic [2:0] PH_UI  = 3'd3;  // inverse of the upper factor
  localparam logic [2:0] PH_OUT = 3'd4;  // product U^-1 * L^-1

  logic [3:0]        state;
  logic [2:0]        phase;
  logic [CW-1:0]     ii;
  logic [CW-1:0]     jj;
  logic [CW-1:0]     m;
  logic [DATA_W-1:0] acc;
  logic              sat_flag;
  logic              sing_flag;
  logic [DIM_W-1:0]  dim;
  logic [IW-1:0]     ld_r;
  logic [IW-1:0]     ld_c;
  logic [IW-1:0]     lr;
  logic [IW-1:0]     lc;
  logic              emit_last;
  logic [DATA_W-1:0] diag [MAX_DIM];

  logic [CW-1:0]     n;
  logic [CW-1:0]     n_last;
  logic [CW-1:0]     m_first;
  logic [CW-1:0]     m_stop;
  logic              accept;
  logic              beyond;
  logic [AW-1:0]     addr_a;
  logic [AW-1:0]     addr_b;
  logic [AW-1:0]     addr_d;
  logic [DATA_W-1:0] op_a;
  logic [DATA_W-1:0] op_b;
  logic [DATA_W:0]   acc_upd;

  // The source store also holds the finished product before it is sent out.
  logic [DATA_W-1:0] src_mem [MD];
  logic [DATA_W-1:0] l_mem   [MD];
  logic [DATA_W-1:0] u_mem   [MD];
  logic [DATA_W-1:0] li_mem  [MD];
  logic [DATA_W-1:0] ui_mem  [MD];
  logic [DATA_W-1:0] src_rd;
  logic [DATA_W-1:0] l_rd;
  logic [DATA_W-1:0] u_rd;
  logic [DATA_W-1:0] li_rd;
  logic [DATA_W-1:0] ui_rd;
  logic              src_we;
  logic [AW-1:0]     src_wa;
  logic [DATA_W-1:0] src_wd;
  logic [AW-1:0]     u_ra;
  logic [AW-1:0]     ui_ra;

  logic              fxu_go;
  logic              div_go;
  fx_res_t           fxu_res;
  fx_res_t           div_res;

  mil_fxu #(.FRAC_BITS(FRAC_BITS)) u_fxu (
    .clk (clk),
    .rst (rst),
    .go  (fxu_go),
    .a   (op_a),
    .b   (op_b),
    .res (fxu_res)
  );

  mil_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk (clk),
    .rst (rst),
    .go  (div_go),
    .num (acc),
    .den (diag[ii[IW-1:0]]),
    .res (div_res)
  );

  always_comb begin
    if (dim == '0) begin
      n = CW'(1);
    end else if (int'(dim) > MAX_DIM) begin
      n = CW'(MAX_DIM);
    end else begin
      n = CW'(dim);
    end
    n_last = n - CW'(1);
  end

  // Range of the summation index for the entry under work (stop is exclusive).
  always_comb begin
    case (phase)
      PH_L: begin
        m_first = '0;
        m_stop  = jj;
      end
      PH_U: begin
        m_first = '0;
        m_stop  = ii;
      end
      PH_LI: begin
        m_first = jj;
        m_stop  = ii;
      end
      PH_UI: begin
        m_first = ii + CW'(1);
        m_stop  = jj + CW'(1);
      end
      default: begin
        m_first = (ii > jj) ? ii : jj;
        m_stop  = n;
      end
    endcase
  end

  always_comb begin
    addr_a = {ii[IW-1:0], m[IW-1:0]};
    addr_b = {m[IW-1:0], jj[IW-1:0]};
    addr_d = {ii[IW-1:0], jj[IW-1:0]};
    u_ra   = (phase == PH_UI) ? addr_a : addr_b;
    ui_ra  = (phase == PH_OUT) ? addr_a : addr_b;
    case (phase)
      PH_L, PH_U: begin
        op_a = l_rd;
        op_b = u_rd;
      end
      PH_LI: begin
        op_a = l_rd;
        op_b = li_rd;
      end
      PH_UI: begin
        op_a = u_rd;
        op_b = ui_rd;
      end
      default: begin
        op_a = ui_rd;
        op_b = li_rd;
      end
    endcase
  end

  assign busy    = (state != S_IDLE) || cfg_we;
  assign accept  = start && !busy;
  // Entries past the last loaded one read as zero.
  assign beyond  = (ii > CW'(lr)) || ((ii == CW'(lr)) && (jj > CW'(lc)));
  assign fxu_go  = (state == S_OP);
  assign div_go  = (state == S_POST) && ((phase == PH_U) || (phase == PH_LI));
  assign acc_upd = fx_addsub(acc, fxu_res.value, phase != PH_OUT);

  always_comb begin
    if (state == S_IDLE) begin
      src_we = accept;
      src_wa = {ld_r, ld_c};
      src_wd = element;
    end else begin
      src_we = (state == S_WR) && (phase == PH_OUT);
      src_wa = addr_d;
      src_wd = acc;
    end
  end

  always_ff @(posedge clk) begin
    if (src_we) begin
      src_mem[src_wa] <= src_wd;
    end
    src_rd <= src_mem[addr_d];
  end

  always_ff @(posedge clk) begin
    if ((state == S_WR) && (phase == PH_L)) begin
      l_mem[addr_d] <= acc;
    end
    l_rd <= l_mem[addr_a];
  end

  always_ff @(posedge clk) begin
    if ((state == S_WR) && (phase == PH_U)) begin
      u_mem[addr_d] <= acc;
    end
    u_rd <= u_mem[u_ra];
  end

  always_ff @(posedge clk) begin
    if ((state == S_WR) && (phase == PH_LI)) begin
      li_mem[addr_d] <= acc;
    end
    li_rd <= li_mem[addr_b];
  end

  always_ff @(posedge clk) begin
    if ((state == S_WR) && (phase == PH_UI)) begin
      ui_mem[addr_d] <= acc;
    end
    ui_rd <= ui_mem[ui_ra];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      phase        <= PH_L;
      ii           <= '0;
      jj           <= '0;
      m            <= '0;
      sat_flag     <= 1'b0;
      sing_flag    <= 1'b0;
      dim          <= DIM_W'(3);
      ld_r         <= '0;
      ld_c         <= '0;
      result_valid <= 1'b0;
      emit_last    <= 1'b0;
    end else begin
      result_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (cfg_we) begin
            dim  <= cfg_wdata;
            ld_r <= '0;
            ld_c <= '0;
          end else if (accept) begin
            if (last_in || ((CW'(ld_r) == n_last) && (CW'(ld_c) == n_last))) begin
              lr        <= ld_r;
              lc        <= ld_c;
              ld_r      <= '0;
              ld_c      <= '0;
              phase     <= PH_L;
              ii        <= '0;
              jj        <= '0;
              sat_flag  <= 1'b0;
              sing_flag <= 1'b0;
              state     <= S_SRC;
            end else if (CW'(ld_c) == n_last) begin
              ld_c <= '0;
              ld_r <= ld_r + IW'(1);
            end else begin
              ld_c <= ld_c + IW'(1);
            end
          end
        end
        S_SRC: begin
          state <= S_INIT;
        end
        S_INIT: begin
          if ((phase == PH_L) || (phase == PH_U)) begin
            acc <= beyond ? '0 : src_rd;
          end else if (((phase == PH_LI) || (phase == PH_UI)) && (ii == jj)) begin
            acc <= FX_ONE;
          end else begin
            acc <= '0;
          end
          m     <= m_first;
          state <= (m_first == m_stop) ? S_POST : S_RD;
        end
        S_RD: begin
          state <= S_OP;
        end
        S_OP: begin
          state <= S_WAIT;
        end
        S_WAIT: begin
          if (fxu_res.done) begin
            acc      <= acc_upd[DATA_W-1:0];
            sat_flag <= sat_flag | fxu_res.sat | acc_upd[DATA_W];
            m        <= m + CW'(1);
            state    <= ((m + CW'(1)) == m_stop) ? S_POST : S_RD;
          end
        end
        S_POST: begin
          state <= div_go ? S_DIV : S_WR;
        end
        S_DIV: begin
          if (div_res.done) begin
            acc      <= div_res.value;
            sat_flag <= sat_flag | div_res.sat;
            state    <= S_WR;
          end
        end
        S_WR: begin
          state <= S_SRC;
          case (phase)
            PH_L: begin
              if (ii == jj) begin
                diag[jj[IW-1:0]] <= acc;
              end
              if ((ii == jj) && (acc == '0)) begin
                // Zero pivot: stop here and send out zeros.
                sing_flag <= 1'b1;
                ii        <= '0;
                jj        <= '0;
                state     <= S_EMIT;
              end else if (ii == n_last) begin
                if (jj == n_last) begin
                  phase <= PH_LI;
                  ii    <= '0;
                  jj    <= '0;
                end else begin
                  phase <= PH_U;
                  ii    <= jj;
                  jj    <= jj + CW'(1);
                end
              end else begin
                ii <= ii + CW'(1);
              end
            end
            PH_U: begin
              if (jj == n_last) begin
                phase <= PH_L;
                ii    <= ii + CW'(1);
                jj    <= ii + CW'(1);
              end else begin
                jj <= jj + CW'(1);
              end
            end
            PH_LI: begin
              if (jj < ii) begin
                jj <= jj + CW'(1);
              end else if (ii < n_last) begin
                ii <= ii + CW'(1);
                jj <= '0;
              end else begin
                phase <= PH_UI;
                ii    <= n_last;
                jj    <= n_last;
              end
            end
            PH_UI: begin
              if (jj > ii) begin
                jj <= jj - CW'(1);
              end else if (ii != '0) begin
                ii <= ii - CW'(1);
                jj <= n_last;
              end else begin
                phase <= PH_OUT;
                ii    <= '0;
                jj    <= '0;
              end
            end
            default: begin
              if (jj < n_last) begin
                jj <= jj + CW'(1);
              end else if (ii < n_last) begin
                ii <= ii + CW'(1);
                jj <= '0;
              end else begin
                ii    <= '0;
                jj    <= '0;
                state <= S_EMIT;
              end
            end
          endcase
        end
        S_EMIT: begin
          // The read issued here returns next cycle, together with the strobe.
          result_valid <= 1'b1;
          emit_last    <= (ii == n_last) && (jj == n_last);
          if (jj < n_last) begin
            jj <= jj + CW'(1);
          end else if (ii < n_last) begin
            ii <= ii + CW'(1);
            jj <= '0;
          end else begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign inv_value = sing_flag ? '0 : src_rd;
  assign last_out  = emit_last;
  assign status    = sing_flag ? ST_SINGULAR : (sat_flag ? ST_OVERFLOW : ST_OK);

endmodule

>>> src/mil_fxu.sv
module mil_fxu import mil_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              go,
  input  logic [DATA_W-1:0] a,
  input  logic [DATA_W-1:0] b,
  output fx_res_t           res
);

  localparam int PW = 2 * DATA_W;
  localparam int RW = PW - FRAC_BITS;

  logic [PW-1:0] prod;
  logic          prod_valid;
  logic          neg;
  logic [PW-1:0] mag;
  logic [PW-1:0] rsum;
  logic [RW-1:0] rnd;
  logic          sat_p;
  logic          sat_n;
  logic          res_valid;
  logic          res_sat;
  logic [DATA_W-1:0] res_value;

  // Magnitude is rounded half away from zero, then the sign is put back.
  always_comb begin
    neg   = prod[PW-1];
    mag   = neg ? (~prod + PW'(1)) : prod;
    rsum  = mag + (PW'(1) << (FRAC_BITS - 1));
    rnd   = rsum[PW-1:FRAC_BITS];
    sat_p = |rnd[RW-1:DATA_W-1];
    sat_n = (|rnd[RW-1:DATA_W]) | (rnd[DATA_W-1] & (|rnd[DATA_W-2:0]));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_valid <= 1'b0;
      res_valid  <= 1'b0;
    end else begin
      prod_valid <= go;
      res_valid  <= prod_valid;
      prod       <= PW'($signed(a) * $signed(b));
      if (neg) begin
        res_sat   <= sat_n;
        res_value <= sat_n ? FX_MIN : (~rnd[DATA_W-1:0] + DATA_W'(1));
      end else begin
        res_sat   <= sat_p;
        res_value <= sat_p ? FX_MAX : rnd[DATA_W-1:0];
      end
    end
  end

  assign res.done  = res_valid;
  assign res.sat   = res_sat;
  assign res.value = res_value;

endmodule

>>> src/mil_div.sv
module mil_div import mil_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              go,
  input  logic [DATA_W-1:0] num,
  input  logic [DATA_W-1:0] den,
  output fx_res_t           res
);

  localparam int NW   = DATA_W + 1 + FRAC_BITS;
  localparam int CNTW = $clog2(NW);

  logic              run;
  logic              fin;
  logic [CNTW-1:0]   cnt;
  logic [NW-1:0]     nq;
  logic [DATA_W-1:0] rem;
  logic [DATA_W-1:0] den_r;
  logic              neg_r;
  logic [DATA_W-1:0] mag_a;
  logic [DATA_W-1:0] mag_b;
  logic [DATA_W:0]   rem_sh;
  logic [DATA_W:0]   diff;
  logic              ge;
  logic              sat_p;
  logic              sat_n;

  always_comb begin
    mag_a  = num[DATA_W-1] ? (~num + DATA_W'(1)) : num;
    mag_b  = den[DATA_W-1] ? (~den + DATA_W'(1)) : den;
    rem_sh = {rem, nq[NW-1]};
    diff   = rem_sh - {1'b0, den_r};
    ge     = rem_sh >= {1'b0, den_r};
    sat_p  = |nq[NW-1:DATA_W-1];
    sat_n  = (|nq[NW-1:DATA_W]) | (nq[DATA_W-1] & (|nq[DATA_W-2:0]));
  end

  // Restoring division, one quotient bit per cycle; the half-divisor is
  // added to the dividend up front so the quotient comes out rounded.
  always_ff @(posedge clk) begin
    if (rst) begin
      run <= 1'b0;
      fin <= 1'b0;
      cnt <= '0;
    end else begin
      fin <= 1'b0;
      if (go) begin
        nq    <= {1'b0, mag_a, {FRAC_BITS{1'b0}}} + NW'(mag_b[DATA_W-1:1]);
        den_r <= mag_b;
        neg_r <= num[DATA_W-1] ^ den[DATA_W-1];
        rem   <= '0;
        cnt   <= '0;
        run   <= 1'b1;
      end else if (run) begin
        rem <= ge ? diff[DATA_W-1:0] : rem_sh[DATA_W-1:0];
        nq  <= {nq[NW-2:0], ge};
        cnt <= cnt + CNTW'(1);
        if (cnt == CNTW'(NW - 1)) begin
          run <= 1'b0;
          fin <= 1'b1;
        end
      end
    end
  end

  assign res.done  = fin;
  assign res.sat   = neg_r ? sat_n : sat_p;
  assign res.value = neg_r ? (sat_n ? FX_MIN : (~nq[DATA_W-1:0] + DATA_W'(1)))
                           : (sat_p ? FX_MAX : nq[DATA_W-1:0]);

endmodule

>>> verif/lu_inverse_checker.sv
// Watches the input, configuration and result channels of the LU inverter,
// predicts every result word, and compares the words in order of arrival.
module lu_inverse_checker import mil_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic              busy,
  input  logic [DATA_W-1:0] element,
  input  logic              last_in,
  input  logic              cfg_we,
  input  logic [DIM_W-1:0]  cfg_wdata,
  input  logic              result_valid,
  input  logic [DATA_W-1:0] inv_value,
  input  logic              last_out,
  input  logic [STAT_W-1:0] status,
  output int                errors,
  output int                pending
);

  localparam int ORDER_MAX = 8;
  localparam int FRAC = 16;
  localparam logic signed [31:0] ONE = 32'sh0001_0000;

  typedef struct packed {
    logic [DATA_W-1:0] value;
    logic              last;
    logic [STAT_W-1:0] stat;
  } inv_word_t;

  typedef logic signed [31:0] fx_t;

  inv_word_t inverse_words[$];
  fx_t src_m[ORDER_MAX][ORDER_MAX];
  fx_t low_m[ORDER_MAX][ORDER_MAX];
  fx_t upp_m[ORDER_MAX][ORDER_MAX];
  fx_t low_inv[ORDER_MAX][ORDER_MAX];
  fx_t upp_inv[ORDER_MAX][ORDER_MAX];
  logic [DIM_W-1:0] order_reg;
  int load_cnt;
  bit clipped;

  assign pending = inverse_words.size();

  function automatic fx_t clip32(input longint v);
    if (v > 64'sd2147483647) begin
      clipped = 1'b1;
      return FX_MAX;
    end
    if (v < -64'sd2147483648) begin
      clipped = 1'b1;
      return FX_MIN;
    end
    return fx_t'(v);
  endfunction

  function automatic fx_t fmul(input fx_t a, input fx_t b);
    longint p, m;
    p = longint'(a) * longint'(b);
    m = ((p < 0 ? -p : p) + (64'sd1 <<< (FRAC - 1))) >>> FRAC;
    return clip32(p < 0 ? -m : m);
  endfunction

  function automatic fx_t fdiv(input fx_t a, input fx_t b);
    longint num, den, q;
    num = (a < 0 ? -longint'(a) : longint'(a)) <<< FRAC;
    den = b < 0 ? -longint'(b) : longint'(b);
    q = (num + den / 2) / den;
    return clip32(((a < 0) != (b < 0)) ? -q : q);
  endfunction

  function automatic fx_t fsub(input fx_t a, input fx_t b);
    return clip32(longint'(a) - longint'(b));
  endfunction

  function automatic fx_t fadd(input fx_t a, input fx_t b);
    return clip32(longint'(a) + longint'(b));
  endfunction

  // Crout factorization, both triangular inverses, then their product.
  task automatic build_inverse(input int n);
    int i, j, k, m;
    fx_t acc;
    fx_t vals[ORDER_MAX*ORDER_MAX];
    bit nonsingular;
    logic [STAT_W-1:0] st;
    inv_word_t w;
    clipped = 1'b0;
    nonsingular = 1'b1;
    for (i = 0; i < ORDER_MAX; i++) begin
      for (j = 0; j < ORDER_MAX; j++) begin
        low_m[i][j] = '0;
        upp_m[i][j] = (i == j) ? ONE : '0;
      end
    end
    for (k = 0; k < n && nonsingular; k++) begin
      for (i = k; i < n; i++) begin
        acc = src_m[i][k];
        for (m = 0; m < k; m++) acc = fsub(acc, fmul(low_m[i][m], upp_m[m][k]));
        low_m[i][k] = acc;
      end
      if (low_m[k][k] == 0) begin
        nonsingular = 1'b0;
      end else begin
        for (j = k + 1; j < n; j++) begin
          acc = src_m[k][j];
          for (m = 0; m < k; m++) acc = fsub(acc, fmul(low_m[k][m], upp_m[m][j]));
          upp_m[k][j] = fdiv(acc, low_m[k][k]);
        end
      end
    end
    if (nonsingular) begin
      for (i = 0; i < n; i++) begin
        for (j = 0; j < n; j++) begin
          acc = '0;
          if (j == i) begin
            acc = fdiv(ONE, low_m[i][i]);
          end else if (j < i) begin
            for (m = j; m < i; m++) acc = fsub(acc, fmul(low_m[i][m], low_inv[m][j]));
            acc = fdiv(acc, low_m[i][i]);
          end
          low_inv[i][j] = acc;
        end
      end
      for (i = n - 1; i >= 0; i--) begin
        for (j = n - 1; j >= 0; j--) begin
          acc = '0;
          if (j == i) begin
            acc = ONE;
          end else if (j > i) begin
            for (m = i + 1; m <= j; m++) acc = fsub(acc, fmul(upp_m[i][m], upp_inv[m][j]));
          end
          upp_inv[i][j] = acc;
        end
      end
    end
    for (i = 0; i < n; i++) begin
      for (j = 0; j < n; j++) begin
        acc = '0;
        if (nonsingular) begin
          for (m = 0; m < n; m++) acc = fadd(acc, fmul(upp_inv[i][m], low_inv[m][j]));
        end
        vals[i*n+j] = acc;
      end
    end
    st = !nonsingular ? ST_SINGULAR : (clipped ? ST_OVERFLOW : ST_OK);
    for (i = 0; i < n * n; i++) begin
      w.value = vals[i];
      w.last = (i == n * n - 1);
      w.stat = st;
      inverse_words.push_back(w);
    end
  endtask

  task automatic take_element(input fx_t value, input logic mark);
    int n, total, k, p;
    n = (order_reg == 0) ? 1 : (order_reg > ORDER_MAX ? ORDER_MAX : int'(order_reg));
    total = n * n;
    k = (load_cnt >= total) ? 0 : load_cnt;
    src_m[k/n][k%n] = value;
    if (k + 1 < total && !mark) begin
      load_cnt = k + 1;
    end else begin
      for (p = k + 1; p < total; p++) src_m[p/n][p%n] = '0;
      load_cnt = 0;
      build_inverse(n);
    end
  endtask

  task automatic report_mismatch(input string what, input logic [DATA_W-1:0] got,
                                 input logic [DATA_W-1:0] want);
    $display("%0t: mismatch on %s: got %h, expected %h", $realtime, what, got, want);
    errors++;
  endtask

  initial errors = 0;

  always @(posedge clk) begin
    inv_word_t w;
    if (rst) begin
      order_reg = 4'd3;
      load_cnt = 0;
      inverse_words.delete();
    end else begin
      if (result_valid) begin
        if (inverse_words.size() == 0) begin
          report_mismatch("unexpected result word", inv_value, '0);
        end else begin
          w = inverse_words.pop_front();
          if (inv_value !== w.value) report_mismatch("inv_value", inv_value, w.value);
          if (last_out !== w.last) report_mismatch("last_out", last_out, w.last);
          if (status !== w.stat) report_mismatch("status", status, w.stat);
        end
      end
      if (cfg_we) begin
        order_reg = cfg_wdata;
        load_cnt = 0;
      end
      if (start && !busy) take_element(element, last_in);
    end
  end

endmodule

>>> verif/testbench.sv
// Top of the LU inverter testbench. It makes the stimulus: directed matrices
// that hit the order extremes, singular and saturating inputs, early and
// missing last marks and a dropped partial load, then random matrices. The
// checker beside the block predicts and compares every result word.
module testbench;
  import mil_pkg::*;

  localparam int WATCHDOG_LIMIT = 200000;
  localparam int ONE = 32'h0001_0000;

  logic              clk;
  logic              rst;
  logic              start;
  logic              busy;
  logic [DATA_W-1:0] element;
  logic              last_in;
  logic              cfg_we;
  logic [DIM_W-1:0]  cfg_wdata;
  logic              result_valid;
  logic [DATA_W-1:0] inv_value;
  logic              last_out;
  logic [STAT_W-1:0] status;
  int                errors;
  int                pending;
  int                idle_pct;
  int                words_sent;
  int                quiet_cycles;

  matrix_inverse_lu_unit DUT (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .element(element), .last_in(last_in),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .result_valid(result_valid), .inv_value(inv_value),
    .last_out(last_out), .status(status)
  );

  lu_inverse_checker checker_i (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .element(element), .last_in(last_in),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .result_valid(result_valid), .inv_value(inv_value),
    .last_out(last_out), .status(status),
    .errors(errors), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // The watchdog restarts whenever any word moves on either channel. A full
  // order-8 inversion stays well under the limit.
  always @(posedge clk) begin
    if (rst || (start && !busy) || result_valid || cfg_we) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Present one word and hold it until the block takes it. The start line is
  // left high afterwards so back-to-back words follow without a gap.
  task automatic send_word(input logic [DATA_W-1:0] value, input logic mark);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    element <= value;
    last_in <= mark;
    do @(posedge clk); while (busy);
    words_sent++;
  endtask

  // The order register may only change with the block idle. Pending is read
  // on the falling edge so the checker's update at the rising edge has landed;
  // the extra cycles cover the tail of the block after its final word.
  task automatic wait_idle();
    start <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_order(input logic [DIM_W-1:0] value);
    wait_idle();
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Random content with a dominant diagonal keeps the factorization well behaved.
  function automatic logic [DATA_W-1:0] friendly_entry(input int n, input int r, input int c);
    int mag;
    if (r == c) begin
      mag = $urandom_range(8 * n * ONE, n * ONE);
      return $urandom_range(1) ? -mag : mag;
    end
    mag = $urandom_range(ONE - 1);
    return $urandom_range(1) ? -mag : mag;
  endfunction

  // Shapes: well-formed, full-range noise, an early last mark, or no mark at all.
  task automatic send_matrix(input int n, input int shape);
    int r, c, cut;
    logic [DATA_W-1:0] v;
    cut = $urandom_range(n * n - 1);
    for (r = 0; r < n; r++) begin
      for (c = 0; c < n; c++) begin
        v = (shape == 1) ? $urandom() : friendly_entry(n, r, c);
        if (shape == 2 && r * n + c == cut) begin
          send_word(v, 1'b1);
          return;
        end
        send_word(v, (shape != 3) && (r == n - 1) && (c == n - 1));
      end
    end
  endtask

  initial begin
    int n, shape, cur_order;
    rst = 1'b1;
    start = 1'b0;
    element = '0;
    last_in = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    idle_pct = 29;
    words_sent = 0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Order 1: unity, zero pivot, both range extremes, and a one-LSB entry
    // whose reciprocal saturates.
    write_order(4'd1);
    send_word(ONE, 1'b1);
    send_word(32'h0, 1'b1);
    send_word(FX_MAX, 1'b1);
    send_word(FX_MIN, 1'b1);
    send_word(32'h1, 1'b1);
    // Order 0 behaves as order 1.
    write_order(4'd0);
    send_word(-2 * ONE, 1'b0);
    // Order 2: a plain matrix, an early mark that leaves it singular, and a
    // partial load that a register write throws away.
    write_order(4'd2);
    send_word(2 * ONE, 1'b0);
    send_word(ONE, 1'b0);
    send_word(ONE, 1'b0);
    send_word(3 * ONE, 1'b1);
    send_word(5 * ONE, 1'b1);
    send_word(ONE, 1'b0);
    send_word(ONE, 1'b0);
    write_order(4'd2);
    send_matrix(2, 0);
    // Orders above the maximum act as the maximum; an early mark zero-fills.
    write_order(4'd15);
    send_word(ONE, 1'b1);
    wait_idle();
    cur_order = 15;

    while (words_sent < 85) begin
      idle_pct = (words_sent < 40) ? 29 : (words_sent < 65) ? 83 : 0;
      n = ($urandom_range(19) == 0) ? 8 : $urandom_range(4, 1);
      if (n != cur_order || $urandom_range(9) == 0) begin
        write_order(n[DIM_W-1:0]);
        cur_order = n;
      end
      shape = $urandom_range(9);
      shape = (shape < 6) ? 0 : (shape < 8) ? 1 : (shape == 8) ? 2 : 3;
      send_matrix(n, shape);
      if ($urandom_range(14) == 0) begin
        send_word($urandom(), 1'b0);
        write_order(n[DIM_W-1:0]);
      end
    end

    wait_idle();
    repeat (30) @(posedge clk);
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
